/* hw/rtl/per_flow_delay_jitter_stats_assert.svh */
// Assertion helpers for the flow statistics block.
`ifndef PER_FLOW_DELAY_JITTER_STATS_ASSERT_SVH
`define PER_FLOW_DELAY_JITTER_STATS_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PFS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hw/rtl/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// Types and codes shared by the flow statistics block.
// ----------------------------------------------------------------------------
package pfs_pkg;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_SHORT = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic REG_EXP_VERSION = 1'b0;
  localparam logic REG_MIN_LENGTH = 1'b1;

  typedef struct packed {
    logic [15:0] packet_length;
    logic [7:0]  header_version;
    logic [15:0] source_id;
    logic [7:0]  qos_class;
    logic [7:0]  slice_type;
    logic [23:0] slice_diff;
    logic [31:0] sequence_number;
    logic [62:0] send_time_ns;
    logic [62:0] arrival_time_ns;
  } pkt_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         flow_slot;
    logic               new_flow;
    logic               reordered;
    logic signed [63:0] delay_ns;
    logic [47:0]        jitter_q4;
    logic [31:0]        flow_packets;
    logic signed [63:0] flow_max_delay_ns;
    logic [31:0]        flow_reorders;
    logic [31:0]        total_packets;
    logic [31:0]        version_errors;
  } res_out_t;

  // Per-flow record kept in the statistics memory.
  typedef struct packed {
    logic [31:0]        packets;
    logic [47:0]        bytes;
    logic [31:0]        highest_seq;
    logic [31:0]        reorders;
    logic signed [63:0] delay_sum;
    logic signed [63:0] delay_max;
    logic [47:0]        jitter;
    logic signed [63:0] last_transit;
    logic [62:0]        first_rx;
    logic [62:0]        last_rx;
  } flow_rec_t;
endpackage

/* hw/rtl/pfs_lookup.sv */
// ----------------------------------------------------------------------------
// pfs_lookup
// Flow key search: walks the key memory one entry per cycle and reports the
// matching entry or the lowest free one.
// ----------------------------------------------------------------------------
module pfs_lookup import pfs_pkg::*; #(
  parameter int FLOWS = 64,
  localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [55:0]   key,
  input  logic          claim,
  input  logic [IW-1:0] claim_slot,
  output logic          done,
  output logic          hit,
  output logic          found,
  output logic [IW-1:0] slot
);
  logic [55:0]   key_mem [FLOWS];
  logic [FLOWS-1:0] valid;
  logic [55:0]   rd_key;
  logic [IW:0]   rd_addr;
  logic [IW:0]   chk_addr;
  logic          busy;
  logic          chk;
  logic          free_seen;
  logic [IW-1:0] free_slot;

  // Claim a slot: write key and set its valid bit.
  always_ff @(posedge clk) begin
    if (claim) key_mem[claim_slot] <= key;
    rd_key <= key_mem[rd_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (claim) valid[claim_slot] <= 1'b1;
  end

  // Sweep addresses; check each registered read in the cycle after its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk <= 1'b0;
      done <= 1'b0;
      rd_addr <= '0;
    end else if (start) begin
      busy <= 1'b1;
      chk <= 1'b0;
      done <= 1'b0;
      rd_addr <= '0;
      free_seen <= 1'b0;
      hit <= 1'b0;
    end else if (busy) begin
      chk_addr <= rd_addr;
      if (rd_addr < (IW+1)'(FLOWS)) rd_addr <= rd_addr + 1'b1;
      if (chk && valid[chk_addr[IW-1:0]] && rd_key == key) begin
        hit <= 1'b1;
        found <= 1'b1;
        slot <= chk_addr[IW-1:0];
        busy <= 1'b0;
        chk <= 1'b0;
        done <= 1'b1;
      end else if (chk) begin
        chk <= rd_addr < (IW+1)'(FLOWS);
        done <= 1'b0;
        if (!valid[chk_addr[IW-1:0]] && !free_seen) begin
          free_seen <= 1'b1;
          free_slot <= chk_addr[IW-1:0];
        end
      end else if (rd_addr == (IW+1)'(FLOWS)) begin
        // Last entry checked: report the lowest free slot, if any
        busy <= 1'b0;
        chk <= 1'b0;
        done <= 1'b1;
        found <= free_seen;
        slot <= free_slot;
      end else begin
        chk <= rd_addr < (IW+1)'(FLOWS);
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end
endmodule

/* hw/rtl/per_flow_delay_jitter_stats.sv */
// ----------------------------------------------------------------------------
// per_flow_delay_jitter_stats
// Per-flow one-way delay and interarrival jitter statistics.
// ----------------------------------------------------------------------------
// One packet beat is taken at a time. Empty, short and wrong-version packets
// give their result through the res register and then the output register.
// A packet that reaches the flow table goes through the key search, which
// reads one key memory entry per cycle and stops at a match but sweeps every
// entry for a new flow or a full table; then the flow record memory is read
// in the read state and updated and written back in the update state.
// A new beat is taken only once the last result leaves the output register,
// or leaves in the same cycle, so with a ready sink the next beat can be
// taken in the same cycle as each result leaves. Valid bits clear at reset.
module per_flow_delay_jitter_stats import pfs_pkg::*; #(
  parameter int FLOWS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pkt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output res_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [7:0] cfg_data
);
  localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_UPD = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state;
  logic [7:0] exp_ver, min_len;
  pkt_in_t pkt;
  logic [31:0] tot_pkts, ver_errs;
  logic [47:0] tot_bytes;
  logic lk_start, lk_claim, lk_done, lk_hit, lk_found;
  logic [IW-1:0] lk_slot, cur_slot;
  logic fresh;
  flow_rec_t rec_mem [FLOWS];
  flow_rec_t rd_rec, new_rec;
  logic signed [63:0] delay;
  res_out_t res;
  res_out_t ok_res, out_next;
  logic reord;
  logic take, to_table;

  function automatic res_out_t status_only(logic [2:0] st);
    res_out_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);
  assign take = in_valid && in_ready;
  assign to_table = (in_data.packet_length != '0) &&
                    !(in_data.packet_length < {8'd0, min_len}) &&
                    (in_data.header_version == exp_ver);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_ver <= 8'd1;
      min_len <= 8'd32;
    end else if (cfg_we) begin
      if (cfg_index == REG_EXP_VERSION) exp_ver <= cfg_data;
      else min_len <= cfg_data;
    end
  end

  pfs_lookup #(.FLOWS(FLOWS)) u_lookup (
    .clk(clk), .rst(rst), .start(lk_start),
    .key({pkt.source_id, pkt.qos_class, pkt.slice_type, pkt.slice_diff}),
    .claim(lk_claim), .claim_slot(cur_slot),
    .done(lk_done), .hit(lk_hit), .found(lk_found), .slot(lk_slot)
  );

  assign delay = $signed({1'b0, pkt.arrival_time_ns} - {1'b0, pkt.send_time_ns});

  // Record memory: registered read, write back in update state.
  always_ff @(posedge clk) begin
    rd_rec <= rec_mem[cur_slot];
    if (state == S_UPD) rec_mem[cur_slot] <= new_rec;
  end

  // Build the updated record.
  always_comb begin
    logic [32:0] p1;
    logic [48:0] b1;
    logic [64:0] ds;
    logic signed [64:0] dd;
    logic [63:0] mag;
    logic [47:0] magc;
    logic [48:0] jj;
    new_rec = rd_rec;
    reord = 1'b0;
    p1 = '0; b1 = '0; ds = '0; dd = '0; mag = '0; magc = '0; jj = '0;
    if (fresh) begin
      new_rec.packets = 32'd1;
      new_rec.bytes = {32'd0, pkt.packet_length};
      new_rec.highest_seq = pkt.sequence_number;
      new_rec.reorders = '0;
      new_rec.delay_sum = delay;
      new_rec.delay_max = delay;
      new_rec.jitter = '0;
      new_rec.first_rx = pkt.arrival_time_ns;
    end else begin
      p1 = {1'b0, rd_rec.packets} + 33'd1;
      new_rec.packets = p1[32] ? '1 : p1[31:0];
      b1 = {1'b0, rd_rec.bytes} + {33'd0, pkt.packet_length};
      new_rec.bytes = b1[48] ? '1 : b1[47:0];
      if (pkt.sequence_number > rd_rec.highest_seq) begin
        new_rec.highest_seq = pkt.sequence_number;
      end else begin
        reord = 1'b1;
        new_rec.reorders = (&rd_rec.reorders) ? rd_rec.reorders : rd_rec.reorders + 1'b1;
      end
      ds = {rd_rec.delay_sum[63], rd_rec.delay_sum} + {delay[63], delay};
      if (ds[64] != ds[63]) new_rec.delay_sum = ds[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else new_rec.delay_sum = ds[63:0];
      if (delay > rd_rec.delay_max) new_rec.delay_max = delay;
      dd = {delay[63], delay} - {rd_rec.last_transit[63], rd_rec.last_transit};
      mag = dd[64] ? 64'(-dd) : dd[63:0];
      magc = (|mag[63:48]) ? '1 : mag[47:0];
      jj = {1'b0, rd_rec.jitter} - {5'd0, rd_rec.jitter[47:4]} + {1'b0, magc};
      new_rec.jitter = jj[48] ? '1 : jj[47:0];
    end
    new_rec.last_transit = delay;
    new_rec.last_rx = pkt.arrival_time_ns;
  end

  // Assemble the result of a table update.
  always_comb begin
    ok_res = '0;
    ok_res.status = ST_OK;
    ok_res.flow_slot = 6'(cur_slot);
    ok_res.new_flow = fresh;
    ok_res.reordered = reord;
    ok_res.delay_ns = delay;
    ok_res.jitter_q4 = new_rec.jitter;
    ok_res.flow_packets = new_rec.packets;
    ok_res.flow_max_delay_ns = new_rec.delay_max;
    ok_res.flow_reorders = new_rec.reorders;
  end

  // Attach the running totals to the outgoing beat.
  always_comb begin
    out_next = res;
    out_next.total_packets = tot_pkts;
    out_next.version_errors = ver_errs;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      tot_pkts <= '0;
      tot_bytes <= '0;
      ver_errs <= '0;
      lk_start <= 1'b0;
      lk_claim <= 1'b0;
    end else begin
      lk_start <= take && to_table;
      lk_claim <= (state == S_UPD) && fresh;
      out_valid <= (state == S_OUT) || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (take) begin
            pkt <= in_data;
            if (in_data.packet_length == '0) begin
              res <= status_only(ST_EMPTY);
              state <= S_OUT;
            end else begin
              if (!(&tot_pkts)) tot_pkts <= tot_pkts + 1'b1;
              tot_bytes <= ((tot_bytes + 48'(in_data.packet_length)) < tot_bytes) ?
                           '1 : tot_bytes + 48'(in_data.packet_length);
              if (in_data.packet_length < {8'd0, min_len}) begin
                res <= status_only(ST_SHORT);
                state <= S_OUT;
              end else if (in_data.header_version != exp_ver) begin
                if (!(&ver_errs)) ver_errs <= ver_errs + 1'b1;
                res <= status_only(ST_VERSION);
                state <= S_OUT;
              end else begin
                state <= S_SRCH;
              end
            end
          end
        end
        S_SRCH: begin
          if (lk_done) begin
            if (!lk_found) begin
              res <= status_only(ST_FULL);
              state <= S_OUT;
            end else begin
              cur_slot <= lk_slot;
              fresh <= !lk_hit;
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          res <= ok_res;
          state <= S_OUT;
        end
        S_OUT: begin
          out_data <= out_next;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "per_flow_delay_jitter_stats_assert.svh"
  `PFS_ASSERT_IMPL(a_no_take_busy, in_valid && in_ready, state == S_IDLE, "beat taken while busy")
  `PFS_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `PFS_ASSERT_IMPL(a_ok_fields, out_valid && out_data.status != ST_OK, out_data.flow_packets == '0, "fields not cleared")
endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives packet beats into the flow statistics block with random gaps and
// stalls, predicts every result from a behavioral model of the flow table,
// and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = 64;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 20000;

  // Flow statistics predictor and queue of pending results
  class flow_scoreboard;
    logic [7:0] exp_version;
    logic [7:0] min_len;
    bit slot_used[NSLOTS];
    logic [55:0] slot_key[NSLOTS];
    logic [31:0] slot_pkts[NSLOTS];
    logic [31:0] slot_high_seq[NSLOTS];
    logic [31:0] slot_reord[NSLOTS];
    longint slot_max[NSLOTS];
    longint slot_last[NSLOTS];
    logic [47:0] slot_jit[NSLOTS];
    logic [31:0] tot_pkts;
    logic [31:0] ver_errs;
    res_out_t pending[$];
    int errors;

    function void clear();
      exp_version = 8'd1;
      min_len = 8'd32;
      foreach (slot_used[i]) slot_used[i] = 0;
      tot_pkts = 0;
      ver_errs = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] val);
      if (idx == REG_EXP_VERSION) exp_version = val;
      else min_len = val;
    endfunction

    function int used_count();
      int n;
      n = 0;
      foreach (slot_used[i]) n += slot_used[i];
      return n;
    endfunction

    // Note one accepted packet beat and queue its expected result
    function void note_packet(pkt_in_t p);
      res_out_t r;
      logic [55:0] key;
      int hit, free_s;
      longint dly;
      logic [63:0] mag;
      logic [48:0] j;
      r = '0;
      hit = -1;
      free_s = -1;
      key = {p.source_id, p.qos_class, p.slice_type, p.slice_diff};
      if (p.packet_length == 0) begin
        r.status = ST_EMPTY;
      end else begin
        if (tot_pkts != MAX32) tot_pkts++;
        if (p.packet_length < min_len) begin
          r.status = ST_SHORT;
        end else if (p.header_version != exp_version) begin
          if (ver_errs != MAX32) ver_errs++;
          r.status = ST_VERSION;
        end else begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (slot_used[i] && slot_key[i] == key) begin
              hit = i;
              break;
            end
            if (!slot_used[i] && free_s < 0) free_s = i;
          end
          if (hit < 0 && free_s < 0) begin
            r.status = ST_FULL;
          end else begin
            dly = longint'({1'b0, p.arrival_time_ns} - {1'b0, p.send_time_ns});
            r.status = ST_OK;
            if (hit < 0) begin
              hit = free_s;
              r.new_flow = 1;
              slot_used[hit] = 1;
              slot_key[hit] = key;
              slot_pkts[hit] = 1;
              slot_high_seq[hit] = p.sequence_number;
              slot_reord[hit] = 0;
              slot_max[hit] = dly;
              slot_jit[hit] = 0;
            end else begin
              if (slot_pkts[hit] != MAX32) slot_pkts[hit]++;
              if (p.sequence_number > slot_high_seq[hit]) begin
                slot_high_seq[hit] = p.sequence_number;
              end else begin
                r.reordered = 1;
                if (slot_reord[hit] != MAX32) slot_reord[hit]++;
              end
              if (dly > slot_max[hit]) slot_max[hit] = dly;
              mag = (dly >= slot_last[hit]) ? dly - slot_last[hit] : slot_last[hit] - dly;
              if (mag > MAX48) mag = MAX48;
              j = {1'b0, slot_jit[hit]} - (slot_jit[hit] >> 4) + mag[47:0];
              slot_jit[hit] = j[48] ? MAX48 : j[47:0];
            end
            slot_last[hit] = dly;
            r.flow_slot = hit[5:0];
            r.delay_ns = dly;
            r.jitter_q4 = slot_jit[hit];
            r.flow_packets = slot_pkts[hit];
            r.flow_max_delay_ns = slot_max[hit];
            r.flow_reorders = slot_reord[hit];
          end
        end
      end
      r.total_packets = tot_pkts;
      r.version_errors = ver_errs;
      pending.push_back(r);
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(res_out_t got);
      res_out_t want;
      if (pending.size() == 0) begin
        $display("%t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report("status", want.status, got.status);
      if (got.flow_slot !== want.flow_slot)
        report("flow_slot", want.flow_slot, got.flow_slot);
      if (got.new_flow !== want.new_flow)
        report("new_flow", want.new_flow, got.new_flow);
      if (got.reordered !== want.reordered)
        report("reordered", want.reordered, got.reordered);
      if (got.delay_ns !== want.delay_ns)
        report("delay_ns", want.delay_ns, got.delay_ns);
      if (got.jitter_q4 !== want.jitter_q4)
        report("jitter_q4", want.jitter_q4, got.jitter_q4);
      if (got.flow_packets !== want.flow_packets)
        report("flow_packets", want.flow_packets, got.flow_packets);
      if (got.flow_max_delay_ns !== want.flow_max_delay_ns)
        report("flow_max_delay_ns", want.flow_max_delay_ns, got.flow_max_delay_ns);
      if (got.flow_reorders !== want.flow_reorders)
        report("flow_reorders", want.flow_reorders, got.flow_reorders);
      if (got.total_packets !== want.total_packets)
        report("total_packets", want.total_packets, got.total_packets);
      if (got.version_errors !== want.version_errors)
        report("version_errors", want.version_errors, got.version_errors);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      $display("%t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  pkt_in_t in_data;
  logic out_valid;
  logic out_ready;
  res_out_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_data;

  flow_scoreboard flows;
  int idle_cycles;
  bit sink_on;

  // Key pool: a few flows reused often so entries see many packets
  logic [55:0] key_pool[16];
  logic [31:0] seq_pool[16];
  longint base_delay[16];

  per_flow_delay_jitter_stats uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Check result beats and count idle cycles at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) flows.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Stall the result side with random gaps, or not at all
  initial begin
    int n;
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (sink_on) begin
        out_ready <= 1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        @(negedge clk);
      end else begin
        n = $urandom_range(0, 11);
        if (n > 0) begin
          out_ready <= 0;
          repeat (n) @(negedge clk);
        end
        out_ready <= 1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        @(negedge clk);
      end
    end
  end

  // Hold one beat until accepted; stay at the falling edge afterward
  task automatic send_packet(pkt_in_t p, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 11) : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    flows.note_packet(p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (flows.pending.size() != 0) @(negedge clk);
    repeat (NSLOTS + 20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    flows.write_reg(idx, val);
    @(negedge clk);
  endtask

  function automatic logic [62:0] rand63();
    return 63'({$urandom(), $urandom()});
  endfunction

  // Build a packet for a pooled flow, mostly well-formed, with random content
  function automatic pkt_in_t pool_packet(int k);
    pkt_in_t p;
    logic [62:0] tx;
    p = '0;
    p.packet_length = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(32, 1500));
    p.header_version = flows.exp_version;
    {p.source_id, p.qos_class, p.slice_type, p.slice_diff} = key_pool[k];
    if ($urandom_range(0, 4) == 0) p.sequence_number = seq_pool[k] - $urandom_range(0, 3);
    else begin
      seq_pool[k] += $urandom_range(1, 3);
      p.sequence_number = seq_pool[k];
    end
    tx = {23'd0, 8'($urandom_range(0, 255)), $urandom()};
    p.send_time_ns = tx;
    p.arrival_time_ns = tx + 63'(base_delay[k] + $urandom_range(0, 4000));
    if ($urandom_range(0, 19) == 0) p.arrival_time_ns = rand63();
    return p;
  endfunction

  function automatic pkt_in_t noise_packet();
    pkt_in_t p;
    logic [255:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom()};
    p = raw[$bits(pkt_in_t)-1:0];
    return p;
  endfunction

  // Main sequence: directed beats, config phases, random beats, table fill
  initial begin
    pkt_in_t p;
    int k;
    flows = new();
    flows.clear();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = REG_EXP_VERSION;
    cfg_data = '0;
    sink_on = 1;
    idle_cycles = 0;
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = 56'({$urandom(), $urandom()});
      seq_pool[i] = $urandom();
      base_delay[i] = longint'($urandom_range(100, 100000));
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: empty, short, wrong version, extremes of the fields
    p = '0;
    send_packet(p, 0);
    p.packet_length = 16'd31;
    p.header_version = 8'd1;
    send_packet(p, 0);
    p.packet_length = 16'hFFFF;
    p.header_version = 8'd2;
    send_packet(p, 0);
    p.header_version = 8'd1;
    p.source_id = '1; p.qos_class = '1; p.slice_type = '1; p.slice_diff = '1;
    p.sequence_number = '1;
    p.send_time_ns = '0;
    p.arrival_time_ns = '1;
    send_packet(p, 0);
    // Reorder at max sequence, most negative delay, jitter toward saturation
    p.send_time_ns = '1;
    p.arrival_time_ns = '0;
    send_packet(p, 0);
    p.sequence_number = '0;
    p.send_time_ns = '0;
    p.arrival_time_ns = '1;
    send_packet(p, 0);
    for (int i = 0; i < 6; i++) begin
      p.send_time_ns = i[0] ? '0 : '1;
      p.arrival_time_ns = i[0] ? '1 : '0;
      send_packet(p, 1);
    end
    p = '0;
    p.packet_length = 16'd32;
    p.header_version = 8'd1;
    send_packet(p, 0);
    send_packet(p, 1);

    // Config extremes, with the sender held until the block is idle
    drain();
    write_reg(REG_EXP_VERSION, 8'hFF);
    write_reg(REG_MIN_LENGTH, 8'h00);
    p = '0;
    p.header_version = 8'hFF;
    p.packet_length = 16'd1;
    send_packet(p, 0);
    p.header_version = 8'h00;
    send_packet(p, 0);
    drain();
    write_reg(REG_EXP_VERSION, 8'h00);
    write_reg(REG_MIN_LENGTH, 8'hFF);
    p.packet_length = 16'd254;
    send_packet(p, 0);
    p.packet_length = 16'd255;
    send_packet(p, 0);
    drain();
    write_reg(REG_EXP_VERSION, 8'd1);
    write_reg(REG_MIN_LENGTH, 8'd32);
    for (int i = 0; i < 16; i++) key_pool[i][55:0] = 56'({$urandom(), $urandom()});

    // Random: mostly pooled flows, some noise; vary idling by phase
    for (int n = 0; n < 550; n++) begin
      if (n == 200) begin
        drain();
        write_reg(REG_EXP_VERSION, 8'($urandom));
        write_reg(REG_MIN_LENGTH, 8'($urandom_range(0, 64)));
      end
      if (n == 400) begin
        drain();
        write_reg(REG_EXP_VERSION, 8'd1);
        write_reg(REG_MIN_LENGTH, 8'd32);
      end
      sink_on = (n % 150) < 40;
      k = $urandom_range(0, 15);
      if ($urandom_range(0, 9) < 8) p = pool_packet(k);
      else p = noise_packet();
      send_packet(p, (n % 150) >= 40);
    end

    // Fill the table until it reports full
    while (flows.used_count() < NSLOTS + 0) begin
      p = pool_packet(0);
      p.packet_length = 16'd100;
      p.source_id = 16'($urandom);
      p.slice_diff = 24'($urandom);
      send_packet(p, 0);
    end
    for (int i = 0; i < 10; i++) begin
      p = pool_packet(0);
      p.packet_length = 16'd100;
      p.source_id = 16'($urandom);
      send_packet(p, 1);
      p = pool_packet($urandom_range(0, 15));
      send_packet(p, 1);
    end

    sink_on = 0;
    in_valid <= 0;
    while (flows.pending.size() != 0) @(negedge clk);
    repeat (NSLOTS + 20) @(negedge clk);
    if (flows.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
